// ===== rtl/med_pkg.sv =====
// Shared types, constants and helpers of the message envelope decoder.
package med_pkg;

    // Frame layout.
    localparam int unsigned HEAD_BYTES = 13;
    localparam int unsigned POS_W      = 9;
    localparam int unsigned COUNT_W    = POS_W + 1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Header offsets.
    localparam logic [POS_W-1:0] OFS_MAGIC0  = 9'd0;
    localparam logic [POS_W-1:0] OFS_MAGIC1  = 9'd1;
    localparam logic [POS_W-1:0] OFS_SCHEMA  = 9'd2;
    localparam logic [POS_W-1:0] OFS_ROUTE   = 9'd3;
    localparam logic [POS_W-1:0] OFS_SRC_LO  = 9'd4;
    localparam logic [POS_W-1:0] OFS_SRC_HI  = 9'd7;
    localparam logic [POS_W-1:0] OFS_MSG_LO  = 9'd8;
    localparam logic [POS_W-1:0] OFS_MSG_HI  = 9'd11;
    localparam logic [POS_W-1:0] OFS_LENGTH  = 9'd12;

    // Magic bytes 'T' and 'N'.
    localparam logic [7:0] MAGIC0 = 8'h54;
    localparam logic [7:0] MAGIC1 = 8'h4E;

    // UTF-8 byte classes and code point limits.
    localparam logic [7:0]  PRINT_LO   = 8'h20;
    localparam logic [7:0]  PRINT_HI   = 8'h7E;
    localparam logic [7:0]  LEAD2_LO   = 8'hC2;
    localparam logic [7:0]  LEAD2_HI   = 8'hDF;
    localparam logic [7:0]  LEAD3_LO   = 8'hE0;
    localparam logic [7:0]  LEAD3_HI   = 8'hEF;
    localparam logic [7:0]  LEAD4_LO   = 8'hF0;
    localparam logic [7:0]  LEAD4_HI   = 8'hF4;
    localparam logic [7:0]  CONT_MASK  = 8'hC0;
    localparam logic [7:0]  CONT_TAG   = 8'h80;
    localparam logic [20:0] CP_MIN3    = 21'h000800;
    localparam logic [20:0] CP_MIN4    = 21'h010000;
    localparam logic [20:0] CP_SURR_LO = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI = 21'h00DFFF;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHEMA_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LIMIT     = 2'd1;
    localparam logic [7:0] SCHEMA_RESET = 8'd1;
    localparam logic [7:0] LIMIT_RESET  = 8'd255;

    // Error codes reported with a finished frame.
    typedef enum logic [3:0] {
        ERR_NONE    = 4'd0,
        ERR_SHORT   = 4'd1,
        ERR_MAGIC   = 4'd2,
        ERR_SCHEMA  = 4'd3,
        ERR_ROUTE   = 4'd4,
        ERR_LENGTH  = 4'd5,
        ERR_SIZE    = 4'd6,
        ERR_UTF8    = 4'd7,
        ERR_ZERO_ID = 4'd8
    } err_t;

    // Configuration values seen by the parser.
    typedef struct packed {
        logic [7:0] schema_version;
        logic [7:0] text_limit;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  text_byte;
        logic        is_text;
        logic        frame_done;
        logic        frame_ok;
        logic [3:0]  error_code;
        logic        route_out;
        logic [31:0] source_out;
        logic [31:0] message_out;
        logic [7:0]  text_length_out;
    } result_t;

    // Keeps the earliest error of the frame.
    function automatic err_t keep_first(input err_t cur, input err_t code);
        keep_first = (cur != ERR_NONE) ? cur : code;
    endfunction

endpackage

// ===== rtl/message_envelope_decoder_top.sv =====
// Top level of the message envelope decoder.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_data_byte, s_last_byte
//  m_        out        m_valid/m_ready    m_text_byte .. m_text_length_out
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// One item per cycle while s_ready is high: each byte is parsed combinationally and its
// result is captured in the result register.
// Header bytes that are not the last byte give no result item.
// s_ready is low only while a held result is stalled by m_ready.
// Reset is synchronous on aresetn low and clears frame state, the configuration registers and the result valid flag.
module message_envelope_decoder_top
    import med_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_last_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_text_byte,
    output logic                 m_is_text,
    output logic                 m_frame_done,
    output logic                 m_frame_ok,
    output logic [3:0]           m_error_code,
    output logic                 m_route_out,
    output logic [31:0]          m_source_out,
    output logic [31:0]          m_message_out,
    output logic [7:0]           m_text_length_out
);

    cfg_t    cfg;
    logic    res_valid;
    result_t res;
    result_t m_res;

    med_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    med_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_fire   (s_valid && s_ready),
        .in_byte   (s_data_byte),
        .in_last   (s_last_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    med_outreg u_outreg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .res_valid (res_valid),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    // Result fields to ports.
    assign m_text_byte       = m_res.text_byte;
    assign m_is_text         = m_res.is_text;
    assign m_frame_done      = m_res.frame_done;
    assign m_frame_ok        = m_res.frame_ok;
    assign m_error_code      = m_res.error_code;
    assign m_route_out       = m_res.route_out;
    assign m_source_out      = m_res.source_out;
    assign m_message_out     = m_res.message_out;
    assign m_text_length_out = m_res.text_length_out;

endmodule

// ===== rtl/med_cfg.sv =====
// Configuration registers of the message envelope decoder.
module med_cfg
    import med_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,
    output cfg_t                 cfg
);

    logic [7:0] schema_reg;
    logic [7:0] limit_reg;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            schema_reg <= SCHEMA_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SCHEMA_VERSION: schema_reg <= cfg_wdata;
                CFG_TEXT_LIMIT:     limit_reg  <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    assign cfg.schema_version = schema_reg;
    assign cfg.text_limit     = limit_reg;

endmodule

// ===== rtl/med_parse.sv =====
// Per-byte frame parser: header capture, UTF-8 check and error tracking.
module med_parse
    import med_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       res_valid,
    output result_t    res
);

    logic [POS_W-1:0] pos_reg,     pos_next;
    logic             route_reg,   route_next;
    logic [31:0]      source_reg,  source_next;
    logic [31:0]      message_reg, message_next;
    logic [7:0]       length_reg,  length_next;
    err_t             err_reg,     err_next;
    logic [1:0]       pend_reg,    pend_next;
    logic [1:0]       seq_reg,     seq_next;
    logic [20:0]      cp_reg,      cp_next;

    logic               is_text;
    logic [20:0]        cp_joined;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] text_end;
    logic [4:0]         lane_shift;

    assign cp_joined  = {cp_reg[14:0], in_byte[5:0]};
    assign lane_shift = {pos_reg[1:0], 3'b000};
    assign count      = {1'b0, pos_reg} + COUNT_W'(1);

    // Next state and result for the byte at the input.
    always_comb begin
        pos_next     = (pos_reg != POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
        route_next   = route_reg;
        source_next  = source_reg;
        message_next = message_reg;
        length_next  = length_reg;
        err_next     = err_reg;
        pend_next    = pend_reg;
        seq_next     = seq_reg;
        cp_next      = cp_reg;
        is_text      = 1'b0;

        if (pos_reg == OFS_MAGIC0) begin
            if (in_byte != MAGIC0) err_next = keep_first(err_next, ERR_MAGIC);
        end else if (pos_reg == OFS_MAGIC1) begin
            if (in_byte != MAGIC1) err_next = keep_first(err_next, ERR_MAGIC);
        end else if (pos_reg == OFS_SCHEMA) begin
            if (in_byte != cfg.schema_version) err_next = keep_first(err_next, ERR_SCHEMA);
        end else if (pos_reg == OFS_ROUTE) begin
            route_next = in_byte[0];
            if (in_byte > 8'd1) err_next = keep_first(err_next, ERR_ROUTE);
        end else if (pos_reg >= OFS_SRC_LO && pos_reg <= OFS_SRC_HI) begin
            source_next = source_reg | ({24'b0, in_byte} << lane_shift);
            if (pos_reg == OFS_SRC_HI && source_next == 32'd0) begin
                err_next = keep_first(err_next, ERR_ZERO_ID);
            end
        end else if (pos_reg >= OFS_MSG_LO && pos_reg <= OFS_MSG_HI) begin
            message_next = message_reg | ({24'b0, in_byte} << lane_shift);
            if (pos_reg == OFS_MSG_HI && message_next == 32'd0) begin
                err_next = keep_first(err_next, ERR_ZERO_ID);
            end
        end else if (pos_reg == OFS_LENGTH) begin
            length_next = in_byte;
            if (in_byte == 8'd0 || in_byte > cfg.text_limit) begin
                err_next = keep_first(err_next, ERR_LENGTH);
            end
        end else if ({1'b0, pos_reg} < COUNT_W'(HEAD_BYTES) + {2'b00, length_reg}) begin
            is_text = 1'b1;
            if (pend_reg == 2'd0) begin
                // Lead byte or printable single byte.
                if (in_byte >= PRINT_LO && in_byte <= PRINT_HI) begin
                    pend_next = 2'd0;
                end else if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI) begin
                    pend_next = 2'd1;
                    seq_next  = 2'd1;
                    cp_next   = {16'b0, in_byte[4:0]};
                end else if (in_byte >= LEAD3_LO && in_byte <= LEAD3_HI) begin
                    pend_next = 2'd2;
                    seq_next  = 2'd2;
                    cp_next   = {17'b0, in_byte[3:0]};
                end else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI) begin
                    pend_next = 2'd3;
                    seq_next  = 2'd3;
                    cp_next   = {18'b0, in_byte[2:0]};
                end else begin
                    err_next = keep_first(err_next, ERR_UTF8);
                end
            end else if ((in_byte & CONT_MASK) != CONT_TAG) begin
                // A broken sequence is dropped.
                err_next  = keep_first(err_next, ERR_UTF8);
                pend_next = 2'd0;
                seq_next  = 2'd0;
                cp_next   = '0;
            end else begin
                cp_next   = cp_joined;
                pend_next = pend_reg - 2'd1;
                if (pend_reg == 2'd1) begin
                    // Sequence complete: reject overlong, surrogate and out of range.
                    if ((seq_reg == 2'd2 && cp_joined < CP_MIN3) ||
                        (seq_reg == 2'd3 && cp_joined < CP_MIN4) ||
                        (cp_joined >= CP_SURR_LO && cp_joined <= CP_SURR_HI) ||
                        cp_joined > CP_MAX) begin
                        err_next = keep_first(err_next, ERR_UTF8);
                    end
                    seq_next = 2'd0;
                    cp_next  = '0;
                end
            end
        end else begin
            err_next = keep_first(err_next, ERR_SIZE);
        end

        // End of frame checks.
        if (in_last) begin
            if (count < COUNT_W'(HEAD_BYTES)) begin
                err_next = keep_first(err_next, ERR_SHORT);
            end else if (count < text_end) begin
                err_next = keep_first(err_next, ERR_SIZE);
            end else if (pend_next != 2'd0) begin
                err_next = keep_first(err_next, ERR_UTF8);
            end
        end
    end

    assign text_end = COUNT_W'(HEAD_BYTES) + {2'b00, length_next};

    // Result item for this byte.
    always_comb begin
        res_valid           = is_text || in_last;
        res.text_byte       = is_text ? in_byte : 8'd0;
        res.is_text         = is_text;
        res.frame_done      = in_last;
        res.frame_ok        = in_last && (err_next == ERR_NONE);
        res.error_code      = in_last ? 4'(err_next) : 4'(ERR_NONE);
        res.route_out       = in_last ? route_next : 1'b0;
        res.source_out      = in_last ? source_next : 32'd0;
        res.message_out     = in_last ? message_next : 32'd0;
        res.text_length_out = in_last ? length_next : 8'd0;
    end

    // Frame state; a last byte starts the next frame from scratch.
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && in_last)) begin
            pos_reg     <= '0;
            route_reg   <= 1'b0;
            source_reg  <= '0;
            message_reg <= '0;
            length_reg  <= '0;
            err_reg     <= ERR_NONE;
            pend_reg    <= '0;
            seq_reg     <= '0;
            cp_reg      <= '0;
        end else if (in_fire) begin
            pos_reg     <= pos_next;
            route_reg   <= route_next;
            source_reg  <= source_next;
            message_reg <= message_next;
            length_reg  <= length_next;
            err_reg     <= err_next;
            pend_reg    <= pend_next;
            seq_reg     <= seq_next;
            cp_reg      <= cp_next;
        end
    end

    // A last byte always leaves the parser at the start of a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_last |=> pos_reg == '0 && err_reg == ERR_NONE && pend_reg == 2'd0)
        else $error("frame state not cleared after last byte");

    // Outstanding continuations never exceed the sequence being decoded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= seq_reg)
        else $error("continuation count above sequence length");

    // Once recorded, an error holds until the frame ends.
    assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg != ERR_NONE && !(in_fire && in_last) |=> $stable(err_reg))
        else $error("first error overwritten inside a frame");

endmodule

// ===== rtl/med_outreg.sv =====
// Result register between the parser and the result channel.
module med_outreg
    import med_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  logic    res_valid,
    input  result_t res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    result_t data_reg;

    // Take a new item whenever the held result leaves or there is none.
    assign s_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= res_valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = data_reg;

    // A frame result reports ok exactly when it carries no error.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && data_reg.frame_done |->
            data_reg.frame_ok == (data_reg.error_code == 4'(ERR_NONE)))
        else $error("frame_ok disagrees with error_code");

    // A result that ends no frame is a text byte with a clear header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !data_reg.frame_done |->
            data_reg.is_text && !data_reg.frame_ok &&
            data_reg.error_code == 4'(ERR_NONE) && data_reg.source_out == 32'd0)
        else $error("text-only result carries frame status");

endmodule
